// ===== hw/rtl/ts_pmt_section_parser_core_macros.svh =====
// ----------------------------------------------------------------------------
// PMT section parser assertion macros
// Shared concurrent assertion forms; the using module provides i_clk and
// i_rst_n.
// ----------------------------------------------------------------------------
`ifndef TS_PMT_SECTION_PARSER_CORE_MACROS_SVH
`define TS_PMT_SECTION_PARSER_CORE_MACROS_SVH

// same-cycle implication
`define TSPMT_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("tspmt assertion failed");

// next-cycle implication
`define TSPMT_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("tspmt assertion failed");

`endif

// ===== hw/rtl/tspmt_pkg.sv =====
// ----------------------------------------------------------------------------
// tspmt_pkg
// Codes, result type and stream type classification for the PMT parser.
// ----------------------------------------------------------------------------
`default_nettype none

package tspmt_pkg;

    // parse phases
    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_HEADER = 3'd1;
    localparam logic [2:0] PH_SKIP   = 3'd2;
    localparam logic [2:0] PH_TYPE   = 3'd3;
    localparam logic [2:0] PH_PID_HI = 3'd4;
    localparam logic [2:0] PH_PID_LO = 3'd5;
    localparam logic [2:0] PH_LEN_HI = 3'd6;
    localparam logic [2:0] PH_LEN_LO = 3'd7;

    // result kinds
    localparam logic [1:0] KIND_PCR   = 2'd0;
    localparam logic [1:0] KIND_ENTRY = 2'd1;
    localparam logic [1:0] KIND_END   = 2'd2;

    // header byte positions
    localparam logic [9:0] POS_PCR_HI = 10'd0;
    localparam logic [9:0] POS_PCR_LO = 10'd1;
    localparam logic [9:0] POS_PIL_HI = 10'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [12:0] pid;
        logic [7:0]  stream_type;
        logic        is_video;
        logic        is_audio;
        logic        is_section;
        logic        done;
        logic        truncated;
    } t_result;

    typedef struct packed {
        logic is_video;
        logic is_audio;
        logic is_section;
    } t_class;

    // ISO 13818-1 stream types; AC3 0x81, DTS 0x8A
    function automatic t_class classify(input logic [7:0] st);
        t_class c;
        c = '0;
        case (st) inside
            8'h01, 8'h02, 8'h10, 8'h1B:               c.is_video   = 1'b1;
            8'h03, 8'h04, 8'h0F, 8'h11, 8'h81, 8'h8A: c.is_audio   = 1'b1;
            8'h05, 8'h06, [8'h0A:8'h0D]:              c.is_section = 1'b1;
            default:                                  c = '0;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ts_pmt_section_parser_core.sv =====
// ----------------------------------------------------------------------------
// ts_pmt_section_parser_core
// MPEG-2 TS PMT section payload parser, one payload byte per beat.
// Results are registered in the output buffer before they reach the master side.
// Throughput: one byte per cycle; set by the single-pass parse state update.
// Input stalls only while the two-deep output buffer is full.
// Reset: synchronous active-low i_rst_n; parser idles, output buffer empties.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ts_pmt_section_parser_core_macros.svh"

module ts_pmt_section_parser_core (
    input  wire          i_clk,
    input  wire          i_rst_n,
    // slave side
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    input  wire  [23:0]  s_axis_tdata,   // [7:0] byte_value, [17:8] payload_length
    input  wire          s_axis_tuser,   // [0] first_byte
    // master side
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    output logic [31:0]  m_axis_tdata,   // [12:0] pid_value, [20:13] stream_type,
                                         // [21] is_video, [22] is_audio,
                                         // [23] is_section, [24] truncated
    output logic [1:0]   m_axis_tuser,   // [1:0] kind
    output logic         m_axis_tlast    // done_res
);
    import tspmt_pkg::*;

    logic    beat_in;
    logic    res_valid;
    t_result res;
    t_result out_res;
    logic    buf_space;
    logic    out_end;
    logic    out_nonentry;
    logic    zero_len_in;

    // a beat is taken whenever the skid stage is free
    assign s_axis_tready = buf_space;
    assign beat_in       = s_axis_tvalid && s_axis_tready;

    // parse state machine: header, descriptor skip, per-stream entries
    tspmt_parse u_parse (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_beat_valid (beat_in),
        .i_byte       (s_axis_tdata[7:0]),
        .i_first      (s_axis_tuser),
        .i_length     (s_axis_tdata[17:8]),
        .o_res_valid  (res_valid),
        .o_res        (res)
    );

    // result register plus skid stage; input waits only once both hold results
    tspmt_outbuf u_outbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (beat_in && res_valid),
        .i_data  (res),
        .o_space (buf_space),
        .o_valid (m_axis_tvalid),
        .o_data  (out_res),
        .i_ready (m_axis_tready)
    );

    assign m_axis_tdata = {7'h00, out_res.truncated, out_res.is_section,
                           out_res.is_audio, out_res.is_video,
                           out_res.stream_type, out_res.pid};
    assign m_axis_tuser = out_res.kind;
    assign m_axis_tlast = out_res.done;

    assign out_end      = m_axis_tvalid && (m_axis_tuser == KIND_END);
    assign out_nonentry = m_axis_tvalid && (m_axis_tuser != KIND_ENTRY);
    assign zero_len_in  = beat_in && s_axis_tuser && (s_axis_tdata[17:8] == '0);

    // end marks always close the section
    `TSPMT_ASSERT_IMP(a_end_is_last, out_end, m_axis_tlast)
    // only stream entries carry a type and class flags
    `TSPMT_ASSERT_IMP(a_nonentry_clean, out_nonentry, m_axis_tdata[23:13] == '0)
    // zero-length first byte: a result beat is valid on the master side next cycle
    `TSPMT_ASSERT_NXT(a_zero_len_result, zero_len_in, m_axis_tvalid)

endmodule

`default_nettype wire

// ===== hw/rtl/tspmt_parse.sv =====
// ----------------------------------------------------------------------------
// tspmt_parse
// Per-byte PMT payload state machine; one result decision per accepted beat.
// ----------------------------------------------------------------------------
`default_nettype none

module tspmt_parse (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_beat_valid,
    input  wire  [7:0]              i_byte,
    input  wire                     i_first,
    input  wire  [9:0]              i_length,
    output logic                    o_res_valid,
    output tspmt_pkg::t_result      o_res
);
    import tspmt_pkg::*;

    logic [2:0]  r_phase,  n_phase;
    logic [9:0]  r_pos,    n_pos;
    logic [9:0]  r_len,    n_len;
    logic [11:0] r_skip,   n_skip;
    logic [7:0]  r_type,   n_type;
    logic [4:0]  r_pidhi,  n_pidhi;

    logic [2:0]  w_phase;
    logic [9:0]  w_pos;
    logic [9:0]  w_len;
    logic [11:0] w_skip;
    logic [7:0]  w_type;
    logic [4:0]  w_pidhi;
    logic [11:0] w_skip_lo;
    logic [11:0] w_skip_dec;
    logic        last;
    t_class      cls;

    // a first byte restarts from a clean header state
    assign w_phase    = i_first ? PH_HEADER : r_phase;
    assign w_pos      = i_first ? '0 : r_pos;
    assign w_len      = i_first ? i_length : r_len;
    assign w_skip     = i_first ? '0 : r_skip;
    assign w_type     = i_first ? '0 : r_type;
    assign w_pidhi    = i_first ? '0 : r_pidhi;
    assign w_skip_lo  = w_skip | {4'h0, i_byte};
    assign w_skip_dec = w_skip - 12'd1;
    assign last       = ({1'b0, w_pos} + 11'd1) == {1'b0, w_len};
    assign cls        = classify(w_type);

    always_comb begin
        n_phase     = w_phase;
        n_pos       = w_pos;
        n_len       = w_len;
        n_skip      = w_skip;
        n_type      = w_type;
        n_pidhi     = w_pidhi;
        o_res_valid = 1'b0;
        o_res       = '0;
        o_res.kind  = KIND_END;
        if (i_first && (i_length == '0)) begin
            o_res_valid     = 1'b1;
            o_res.done      = 1'b1;
            o_res.truncated = 1'b1;
            n_phase         = PH_IDLE;
        end else if (w_phase != PH_IDLE) begin
            case (w_phase)
                PH_HEADER: begin
                    if (w_pos == POS_PCR_HI) begin
                        n_pidhi         = i_byte[4:0];
                        o_res_valid     = last;
                        o_res.done      = last;
                        o_res.truncated = last;
                    end else if (w_pos == POS_PCR_LO) begin
                        o_res_valid     = 1'b1;
                        o_res.kind      = KIND_PCR;
                        o_res.pid       = {w_pidhi, i_byte};
                        o_res.done      = last;
                        o_res.truncated = last;
                    end else if (w_pos == POS_PIL_HI) begin
                        n_skip          = {i_byte[3:0], 8'h00};
                        o_res_valid     = last;
                        o_res.done      = last;
                        o_res.truncated = last;
                    end else begin
                        n_skip      = w_skip_lo;
                        n_phase     = (w_skip_lo == '0) ? PH_TYPE : PH_SKIP;
                        o_res_valid = last;
                        o_res.done  = last;
                    end
                end
                PH_SKIP: begin
                    n_skip      = w_skip_dec;
                    if (w_skip_dec == '0) begin
                        n_phase = PH_TYPE;
                    end
                    o_res_valid = last;
                    o_res.done  = last;
                end
                PH_TYPE: begin
                    n_type          = i_byte;
                    n_phase         = PH_PID_HI;
                    o_res_valid     = last;
                    o_res.done      = last;
                    o_res.truncated = last;
                end
                PH_PID_HI: begin
                    n_pidhi         = i_byte[4:0];
                    n_phase         = PH_PID_LO;
                    o_res_valid     = last;
                    o_res.done      = last;
                    o_res.truncated = last;
                end
                PH_PID_LO: begin
                    n_phase           = PH_LEN_HI;
                    o_res_valid       = 1'b1;
                    o_res.kind        = KIND_ENTRY;
                    o_res.pid         = {w_pidhi, i_byte};
                    o_res.stream_type = w_type;
                    o_res.is_video    = cls.is_video;
                    o_res.is_audio    = cls.is_audio;
                    o_res.is_section  = cls.is_section;
                    o_res.done        = last;
                    o_res.truncated   = last;
                end
                PH_LEN_HI: begin
                    n_skip          = {i_byte[3:0], 8'h00};
                    n_phase         = PH_LEN_LO;
                    o_res_valid     = last;
                    o_res.done      = last;
                    o_res.truncated = last;
                end
                PH_LEN_LO: begin
                    n_skip      = w_skip_lo;
                    n_phase     = (w_skip_lo == '0) ? PH_TYPE : PH_SKIP;
                    o_res_valid = last;
                    o_res.done  = last;
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
            if (last) begin
                n_phase = PH_IDLE;
            end else begin
                n_pos = w_pos + 10'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_pos   <= '0;
            r_len   <= '0;
            r_skip  <= '0;
            r_type  <= '0;
            r_pidhi <= '0;
        end else if (i_beat_valid) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_len   <= n_len;
            r_skip  <= n_skip;
            r_type  <= n_type;
            r_pidhi <= n_pidhi;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/tspmt_outbuf.sv =====
// ----------------------------------------------------------------------------
// tspmt_outbuf
// Output register with skid stage; ready toward the parser is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module tspmt_outbuf (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_push,
    input  tspmt_pkg::t_result      i_data,
    output logic                    o_space,
    output logic                    o_valid,
    output tspmt_pkg::t_result      o_data,
    input  wire                     i_ready
);
    import tspmt_pkg::*;

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    drain;

    assign drain   = r_out_valid && i_ready;
    assign o_space = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (r_skid_valid) begin
                if (drain) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end
            end else if (i_push) begin
                if (!r_out_valid || drain) begin
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid_valid <= 1'b1;
                end
            end else if (drain) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (drain) begin
                r_out <= r_skid;
            end
        end else if (i_push) begin
            if (!r_out_valid || drain) begin
                r_out <= i_data;
            end else begin
                r_skid <= i_data;
            end
        end
    end

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: PMT section parser core bench
// Feeds PMT section payloads into the parser one byte per beat. The sections
// are mostly well-formed, with some cut short, padded, abandoned by a restart,
// or surrounded by stray bytes. A local model of the parser predicts the
// result beats, and a monitor checks every result beat field by field. The
// sender and the receiver both idle at random, and one long receiver
// hold-off fills the output buffer so that the input side has to stall.
// ----------------------------------------------------------------------------
module tb_top;

    import tspmt_pkg::*;

    // stream type codes used by the class flags
    localparam logic [7:0] ST_MPEG1_VIDEO = 8'h01;
    localparam logic [7:0] ST_MPEG2_VIDEO = 8'h02;
    localparam logic [7:0] ST_MPEG1_AUDIO = 8'h03;
    localparam logic [7:0] ST_MPEG2_AUDIO = 8'h04;
    localparam logic [7:0] ST_PRIV_SECT   = 8'h05;
    localparam logic [7:0] ST_PRIV_PES    = 8'h06;
    localparam logic [7:0] ST_DSMCC_A     = 8'h0A;
    localparam logic [7:0] ST_DSMCC_B     = 8'h0B;
    localparam logic [7:0] ST_DSMCC_C     = 8'h0C;
    localparam logic [7:0] ST_DSMCC_D     = 8'h0D;
    localparam logic [7:0] ST_AAC         = 8'h0F;
    localparam logic [7:0] ST_MPEG4_VIDEO = 8'h10;
    localparam logic [7:0] ST_MPEG4_AUDIO = 8'h11;
    localparam logic [7:0] ST_H264        = 8'h1B;
    localparam logic [7:0] ST_AC3         = 8'h81;
    localparam logic [7:0] ST_DTS         = 8'h8A;

    localparam int unsigned RANDOM_BYTES = 1250;
    localparam int unsigned LONG_AFTER   = 100;
    localparam int unsigned SHOW_LIMIT   = 10;

    // one input beat before packing
    typedef struct packed {
        logic [7:0] value;
        logic       first;
        logic [9:0] length;
    } t_pmt_beat;

    // receiver stall patterns
    typedef enum logic [1:0] {
        RX_OPEN,
        RX_RANDOM,
        RX_SPARSE,
        RX_TOGGLE
    } t_rx_mode;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [23:0]  s_axis_tdata = '0;   // [7:0] byte_value, [17:8] payload_length
    logic         s_axis_tuser = 1'b0; // [0] first_byte
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [31:0]  m_axis_tdata;        // [12:0] pid_value, [20:13] stream_type,
                                       // [21] is_video, [22] is_audio,
                                       // [23] is_section, [24] truncated
    logic [1:0]   m_axis_tuser;        // [1:0] kind
    logic         m_axis_tlast;        // done_res

    ts_pmt_section_parser_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #6 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    t_pmt_beat   pend_beats [$];     // bytes still to be offered, oldest first
    t_result     pmt_expected [$];   // predicted result beats, oldest first

    int unsigned rand_items       = 0;
    int unsigned beats_in         = 0;
    int unsigned sections_started = 0;
    int unsigned in_stalls        = 0;
    int unsigned fail_count       = 0;
    int unsigned kind_seen [0:3]  = '{default: 0};
    int unsigned trunc_seen       = 0;
    int unsigned video_seen       = 0;
    int unsigned audio_seen       = 0;
    int unsigned sect_seen        = 0;

    // sender pacing
    int unsigned burst_left = 20;
    int unsigned gap_left   = 0;

    // receiver pacing
    int unsigned rx_cycle  = 0;
    int unsigned hold_left = 0;
    bit          hold_done = 1'b0;
    t_rx_mode    rx_mode   = RX_OPEN;

    // parser model state, idle after reset
    logic [2:0]  sec_phase  = PH_IDLE;
    logic [9:0]  sec_pos    = '0;
    logic [9:0]  sec_len    = '0;
    logic [11:0] sec_skip   = '0;
    logic [7:0]  sec_type   = '0;
    logic [4:0]  sec_pid_hi = '0;

    // ------------------------------------------------------------------------
    // Parser model
    // ------------------------------------------------------------------------

    // Builds one result beat; class flags only mean something on an entry,
    // and an end beat carries neither PID nor type.
    function automatic t_result pmt_result(input logic [1:0] kind, input logic [12:0] pid,
                                           input logic [7:0] st, input logic done,
                                           input logic trunc);
        t_result r;
        r = '0;
        r.kind      = kind;
        r.done      = done;
        r.truncated = trunc;
        if (kind != KIND_END) begin
            r.pid = pid;
        end
        if (kind == KIND_ENTRY) begin
            r.stream_type = st;
            r.is_video    = (st == ST_MPEG1_VIDEO) || (st == ST_MPEG2_VIDEO) ||
                            (st == ST_MPEG4_VIDEO) || (st == ST_H264);
            r.is_audio    = (st == ST_MPEG1_AUDIO) || (st == ST_MPEG2_AUDIO) ||
                            (st == ST_AAC) || (st == ST_MPEG4_AUDIO) ||
                            (st == ST_AC3) || (st == ST_DTS);
            r.is_section  = (st == ST_PRIV_SECT) || (st == ST_PRIV_PES) ||
                            (st >= ST_DSMCC_A && st <= ST_DSMCC_D);
        end
        return r;
    endfunction

    // Appends one predicted result beat.
    task automatic expect_result(input t_result r);
        pmt_expected.insert(pmt_expected.size(), r);
    endtask

    // Advances the model by one accepted byte and queues the result it gives.
    task automatic predict_byte(input logic [7:0] b, input logic first,
                                input logic [9:0] len);
        logic last;
        if (first) begin
            // a first byte restarts from any state
            sec_len    = len;
            sec_pos    = '0;
            sec_skip   = '0;
            sec_type   = '0;
            sec_pid_hi = '0;
            sec_phase  = PH_HEADER;
            if (len == 10'd0) begin
                expect_result(pmt_result(KIND_END, '0, '0, 1'b1, 1'b1));
                sec_phase = PH_IDLE;
                return;
            end
        end
        if (sec_phase == PH_IDLE) begin
            return;     // stray byte, no parse running
        end
        last = ({1'b0, sec_pos} + 11'd1 == {1'b0, sec_len});
        case (sec_phase)
            PH_HEADER: begin
                if (sec_pos == POS_PCR_HI) begin
                    sec_pid_hi = b[4:0];
                    if (last) begin
                        expect_result(pmt_result(KIND_END, '0, '0, 1'b1, 1'b1));
                    end
                end else if (sec_pos == POS_PCR_LO) begin
                    expect_result(pmt_result(KIND_PCR, {sec_pid_hi, b}, '0, last, last));
                end else if (sec_pos == POS_PIL_HI) begin
                    sec_skip = {b[3:0], 8'h00};
                    if (last) begin
                        expect_result(pmt_result(KIND_END, '0, '0, 1'b1, 1'b1));
                    end
                end else begin
                    sec_skip  = {sec_skip[11:8], b};
                    sec_phase = (sec_skip == 12'd0) ? PH_TYPE : PH_SKIP;
                    if (last) begin
                        expect_result(pmt_result(KIND_END, '0, '0, 1'b1, 1'b0));
                    end
                end
            end
            PH_SKIP: begin
                sec_skip = sec_skip - 12'd1;
                if (sec_skip == 12'd0) begin
                    sec_phase = PH_TYPE;
                end
                if (last) begin
                    expect_result(pmt_result(KIND_END, '0, '0, 1'b1, 1'b0));
                end
            end
            PH_TYPE: begin
                sec_type  = b;
                sec_phase = PH_PID_HI;
                if (last) begin
                    expect_result(pmt_result(KIND_END, '0, '0, 1'b1, 1'b1));
                end
            end
            PH_PID_HI: begin
                sec_pid_hi = b[4:0];
                sec_phase  = PH_PID_LO;
                if (last) begin
                    expect_result(pmt_result(KIND_END, '0, '0, 1'b1, 1'b1));
                end
            end
            PH_PID_LO: begin
                expect_result(pmt_result(KIND_ENTRY, {sec_pid_hi, b}, sec_type,
                                         last, last));
                sec_phase = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                sec_skip  = {b[3:0], 8'h00};
                sec_phase = PH_LEN_LO;
                if (last) begin
                    expect_result(pmt_result(KIND_END, '0, '0, 1'b1, 1'b1));
                end
            end
            default: begin  // ES info length, low byte
                sec_skip  = {sec_skip[11:8], b};
                sec_phase = (sec_skip == 12'd0) ? PH_TYPE : PH_SKIP;
                if (last) begin
                    expect_result(pmt_result(KIND_END, '0, '0, 1'b1, 1'b0));
                end
            end
        endcase
        if (last) begin
            sec_phase = PH_IDLE;
        end else begin
            sec_pos = sec_pos + 10'd1;
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------

    task automatic push_beat(input logic [7:0] value, input logic first,
                             input logic [9:0] length);
        t_pmt_beat bt;
        bt.value  = value;
        bt.first  = first;
        bt.length = length;
        pend_beats.insert(pend_beats.size(), bt);
    endtask

    // Mostly the classified codes, some near misses, the rest anything.
    function automatic logic [7:0] pick_stream_type();
        int unsigned sel;
        logic [7:0]  v;
        sel = $urandom_range(0, 27);
        v   = 8'($urandom);
        case (sel)
            0:  v = ST_MPEG1_VIDEO;
            1:  v = ST_MPEG2_VIDEO;
            2:  v = ST_MPEG1_AUDIO;
            3:  v = ST_MPEG2_AUDIO;
            4:  v = ST_PRIV_SECT;
            5:  v = ST_PRIV_PES;
            6:  v = ST_DSMCC_A;
            7:  v = ST_DSMCC_B;
            8:  v = ST_DSMCC_C;
            9:  v = ST_DSMCC_D;
            10: v = ST_AAC;
            11: v = ST_MPEG4_VIDEO;
            12: v = ST_MPEG4_AUDIO;
            13: v = ST_H264;
            14: v = ST_AC3;
            15: v = ST_DTS;
            16: v = ST_DSMCC_A - 8'd1;
            17: v = ST_DSMCC_D + 8'd1;
            18: v = ST_AC3 - 8'd1;
            19: v = ST_DTS + 8'd1;
            20: v = 8'h00;
            21: v = 8'hFF;
            default: ;
        endcase
        return v;
    endfunction

    // Descriptor loop length: mostly short, now and then far past the end.
    function automatic logic [11:0] pick_desc_len(input bit tame);
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 7 || tame) begin
            return 12'($urandom_range(0, 4));
        end else if (r < 9) begin
            return 12'($urandom_range(0, 15));
        end
        return 12'($urandom_range(0, 4095));
    endfunction

    // Queues one section. long_len of zero gives a short section whose end is
    // natural, cut short, padded or abandoned; otherwise the section fills
    // exactly long_len bytes.
    task automatic queue_section(input int unsigned long_len);
        logic [7:0]  body [$];
        logic [7:0]  tmp;
        logic [12:0] pid;
        logic [11:0] dlen;
        int unsigned limit, natural, target, send_n, i, r;
        bit          abandoned;

        limit     = (long_len != 0) ? long_len : 64;
        abandoned = 1'b0;

        // header: PCR PID with random reserved bits, program info length
        pid = 13'($urandom_range(0, 8191));
        tmp = 8'($urandom);
        tmp[4:0] = pid[12:8];
        body.insert(body.size(), tmp);
        body.insert(body.size(), pid[7:0]);
        dlen = pick_desc_len(long_len != 0);
        tmp = 8'($urandom);
        tmp[3:0] = dlen[11:8];
        body.insert(body.size(), tmp);
        body.insert(body.size(), dlen[7:0]);
        for (i = 0; i < dlen && body.size() < limit; i++) begin
            body.insert(body.size(), 8'($urandom));
        end

        // elementary stream entries
        r = (long_len != 0) ? 1000 : $urandom_range(0, 4);
        while (r > 0 && body.size() < limit) begin
            body.insert(body.size(), pick_stream_type());
            pid = 13'($urandom_range(0, 8191));
            tmp = 8'($urandom);
            tmp[4:0] = pid[12:8];
            body.insert(body.size(), tmp);
            body.insert(body.size(), pid[7:0]);
            dlen = pick_desc_len(long_len != 0);
            tmp = 8'($urandom);
            tmp[3:0] = dlen[11:8];
            body.insert(body.size(), tmp);
            body.insert(body.size(), dlen[7:0]);
            for (i = 0; i < dlen && body.size() < limit; i++) begin
                body.insert(body.size(), 8'($urandom));
            end
            r--;
        end

        natural = body.size();
        target  = natural;
        if (long_len != 0) begin
            target = long_len;
        end else begin
            r = $urandom_range(0, 9);
            if (r == 6 || r == 7) begin
                target = natural - $urandom_range(1, (natural > 7) ? 6 : natural - 1);
            end else if (r == 8) begin
                target = natural + $urandom_range(1, 8);
            end else if (r == 9) begin
                abandoned = 1'b1;
            end
        end
        while (body.size() < target) begin
            body.insert(body.size(), 8'($urandom));
        end
        send_n = abandoned ? $urandom_range(1, target - 1) : target;

        for (i = 0; i < send_n; i++) begin
            // the length field is ignored after the first byte, so it is noise
            push_beat(body[i], i == 0,
                      (i == 0) ? 10'(target) : 10'($urandom_range(0, 1023)));
        end
        rand_items += send_n;

        // stray bytes between sections, which the parser must ignore
        if (!abandoned && $urandom_range(0, 5) == 0) begin
            r = $urandom_range(1, 3);
            for (i = 0; i < r; i++) begin
                push_beat(8'($urandom), 1'b0, 10'($urandom_range(0, 1023)));
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Sender: bursts of beats with random gaps; valid holds until taken
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : beat_driver
        t_pmt_beat nxt;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                // predict from what the block actually sampled
                predict_byte(s_axis_tdata[7:0], s_axis_tuser, s_axis_tdata[17:8]);
                if (s_axis_tuser) begin
                    sections_started++;
                end
                void'(pend_beats.pop_front());
                beats_in++;
                if (burst_left > 0) begin
                    burst_left--;
                end
                if (burst_left == 0) begin
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    burst_left = $urandom_range(1, 40);
                end
            end
            if (s_axis_tvalid && !s_axis_tready) begin
                in_stalls++;        // beat held, nothing changes
            end else if (gap_left > 0) begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end else if (pend_beats.size() != 0) begin
                nxt = pend_beats[0];
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {6'd0, nxt.length, nxt.value};
                s_axis_tuser  <= nxt.first;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: switches among random stall patterns; one long hold-off
    // once the run is under way fills the output buffer
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : result_sink
        logic rdy;
        rdy = 1'b0;
        if (i_rst_n) begin
            rx_cycle++;
            if (!hold_done && beats_in >= 600) begin
                hold_left = 400;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
            end else begin
                if (rx_cycle % 64 == 0) begin
                    rx_mode = t_rx_mode'($urandom_range(0, 3));
                end
                case (rx_mode)
                    RX_OPEN:   rdy = 1'b1;
                    RX_RANDOM: rdy = 1'($urandom_range(0, 1));
                    RX_SPARSE: rdy = ($urandom_range(0, 3) == 0);
                    default:   rdy = rx_cycle[2];
                endcase
            end
        end
        m_axis_tready <= rdy;
    end

    // ------------------------------------------------------------------------
    // Monitor: each result beat against the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : result_check
        t_result got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.kind        = m_axis_tuser;
            got.pid         = m_axis_tdata[12:0];
            got.stream_type = m_axis_tdata[20:13];
            got.is_video    = m_axis_tdata[21];
            got.is_audio    = m_axis_tdata[22];
            got.is_section  = m_axis_tdata[23];
            got.truncated   = m_axis_tdata[24];
            got.done        = m_axis_tlast;
            if (pmt_expected.size() == 0) begin
                fail_count++;
                if (fail_count <= SHOW_LIMIT) begin
                    $display("%0t: unexpected result beat kind=%0d pid=%h", $realtime,
                             got.kind, got.pid);
                end
            end else begin
                want = pmt_expected.pop_front();
                kind_seen[want.kind]++;
                trunc_seen += want.truncated;
                video_seen += want.is_video;
                audio_seen += want.is_audio;
                sect_seen  += want.is_section;
                if (got.kind !== want.kind || got.pid !== want.pid ||
                    got.stream_type !== want.stream_type ||
                    got.is_video !== want.is_video || got.is_audio !== want.is_audio ||
                    got.is_section !== want.is_section || got.done !== want.done ||
                    got.truncated !== want.truncated) begin
                    fail_count++;
                    if (fail_count <= SHOW_LIMIT) begin
                        $display("%0t: result mismatch", $realtime);
                        $display({"  expected kind=%0d pid=%h type=%h v/a/s=%b%b%b",
                                  " done=%b trunc=%b"},
                                 want.kind, want.pid, want.stream_type, want.is_video,
                                 want.is_audio, want.is_section, want.done, want.truncated);
                        $display({"  actual   kind=%0d pid=%h type=%h v/a/s=%b%b%b",
                                  " done=%b trunc=%b"},
                                 got.kind, got.pid, got.stream_type, got.is_video,
                                 got.is_audio, got.is_section, got.done, got.truncated);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sequence: directed sections, random sections, drain, verdict
    // ------------------------------------------------------------------------
    initial begin : run_sequence
        bit long_done;
        long_done = 1'b0;
        // stray byte while idle: ignored
        push_beat(8'h5A, 1'b0, 10'd77);
        // zero length: immediate end, truncated
        push_beat(8'h00, 1'b1, 10'd0);
        // payload ends on the PCR high byte
        push_beat(8'hFF, 1'b1, 10'd1);
        // ends on the PCR low byte: all-ones PID, truncated
        push_beat(8'hFF, 1'b1, 10'd2);
        push_beat(8'hFF, 1'b0, 10'd1023);
        // ends on the program info length high byte
        push_beat(8'hE0, 1'b1, 10'd3);
        push_beat(8'h00, 1'b0, 10'd0);
        push_beat(8'hF0, 1'b0, 10'd0);
        // ends cleanly after the header, no entries
        push_beat(8'hE0, 1'b1, 10'd4);
        push_beat(8'h00, 1'b0, 10'd0);
        push_beat(8'hF0, 1'b0, 10'd0);
        push_beat(8'h00, 1'b0, 10'd0);
        // top-of-range length, abandoned at once by the next first byte
        push_beat(8'h00, 1'b1, 10'd1023);
        // one descriptor byte, an H.264 entry, then a DTS entry cut at PID high
        push_beat(8'hE1, 1'b1, 10'd12);
        push_beat(8'h00, 1'b0, 10'd0);
        push_beat(8'hF0, 1'b0, 10'd0);
        push_beat(8'h01, 1'b0, 10'd0);
        push_beat(8'h05, 1'b0, 10'd0);
        push_beat(ST_H264, 1'b0, 10'd0);
        push_beat(8'hE1, 1'b0, 10'd0);
        push_beat(8'h01, 1'b0, 10'd0);
        push_beat(8'hF0, 1'b0, 10'd0);
        push_beat(8'h00, 1'b0, 10'd0);
        push_beat(ST_DTS, 1'b0, 10'd0);
        push_beat(8'hFF, 1'b0, 10'd0);

        // random sections, with one long section above the nominal range
        while (rand_items < RANDOM_BYTES) begin
            queue_section(0);
            if (!long_done && rand_items >= LONG_AFTER) begin
                queue_section($urandom_range(1013, 1023));
                long_done = 1'b1;
            end
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // all beats taken, then all results back, then a short tail
        while (pend_beats.size() != 0) begin
            @(posedge i_clk);
        end
        while (pmt_expected.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (10) @(posedge i_clk);

        $display("covered %0d payload bytes in %0d sections; results: %0d PCR, %0d entry,",
                 beats_in, sections_started, kind_seen[KIND_PCR], kind_seen[KIND_ENTRY]);
        $display("%0d end, %0d truncated; classes: %0d video, %0d audio, %0d private/DSM-CC;",
                 kind_seen[KIND_END], trunc_seen, video_seen, audio_seen, sect_seen);
        $display("input stalled %0d cycles", in_stalls);
        if (fail_count == 0 && pmt_expected.size() == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // Watchdog: fails a run that goes on far beyond the slowest correct run
    // ------------------------------------------------------------------------
    initial begin : watchdog
        repeat (500_000) @(posedge i_clk);
        $display("tb_top failed");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/tspmt_pkg.sv
hw/rtl/tspmt_parse.sv
hw/rtl/tspmt_outbuf.sv
hw/rtl/ts_pmt_section_parser_core.sv
bench/tb_top.sv
